// File: rtl/blockable_road_shortest_path_top_defines.svh
// Assertion macros for the blockable road shortest path block.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef BLOCKABLE_ROAD_SHORTEST_PATH_TOP_DEFINES_SVH
`define BLOCKABLE_ROAD_SHORTEST_PATH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BRSP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("brsp assertion failed");
`define BRSP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("brsp assertion failed");
`else
`define BRSP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BRSP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/brsp_pkg.sv
// Shared types and constants of the blockable road shortest path block.
// No dependencies.
package brsp_pkg;

    localparam int ROUTE_MAX = 16;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_BLOCK   = 2'd1,
        OP_UNBLOCK = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_ROUTE  = 2'd1,
        STS_NO_ROAD   = 2'd2,
        STS_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ROAD_WAIT,
        ST_ROAD_WR2,
        ST_RESP,
        ST_INIT,
        ST_SCAN,
        ST_SETTLE,
        ST_RELAX,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic    in_ready;
        logic    take_in;
        logic    clr_step;
        logic    road_wr_ab;
        logic    road_wr_ba;
        logic    cnt_clr;
        logic    best_clr;
        logic    init_step;
        logic    scan_step;
        logic    settle_wr;
        logic    relax_step;
        logic    walk_start;
        logic    walk_rd;
        logic    walk_push;
        logic    emit_load;
        logic    resp_load;
        status_t resp_code;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic bad_index;
        logic is_query;
        logic is_add;
        logic road_present;
        logic cnt_done;
        logic pipe_busy;
        logic found;
        logic rd_reached;
        logic len_zero;
        logic walk_end;
        logic pos_zero;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/brsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// File: rtl/brsp_ctrl.sv
// Controller state machine of the shortest path block.
// Depends on brsp_pkg; drives brsp_datapath through cmd_t.
module brsp_ctrl import brsp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            code_reg  <= STS_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.bad_index) begin
                    state_next = ST_RESP;
                    code_next  = STS_BAD_INDEX;
                end else if (sts.is_query) begin
                    state_next = ST_INIT;
                end else begin
                    state_next = ST_ROAD_WAIT;
                end
            end
            ST_ROAD_WAIT: begin
                if (!sts.is_add && !sts.road_present) begin
                    state_next = ST_RESP;
                    code_next  = STS_NO_ROAD;
                end else begin
                    state_next = ST_ROAD_WR2;
                end
            end
            ST_ROAD_WR2: begin
                state_next = ST_RESP;
                code_next  = STS_OK;
            end
            ST_RESP: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_INIT: begin
                if (sts.cnt_done) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.cnt_done && !sts.pipe_busy) begin
                    state_next = sts.found ? ST_SETTLE : ST_WALK_RD;
                end
            end
            ST_SETTLE: state_next = ST_RELAX;
            ST_RELAX: begin
                if (sts.cnt_done && !sts.pipe_busy) state_next = ST_SCAN;
            end
            ST_WALK_RD: state_next = ST_WALK_EV;
            ST_WALK_EV: begin
                if (sts.len_zero && !sts.rd_reached) begin
                    state_next = ST_RESP;
                    code_next  = STS_NO_ROUTE;
                end else begin
                    state_next = sts.walk_end ? ST_EMIT_RD : ST_WALK_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (sts.out_free) state_next = sts.pos_zero ? ST_IDLE : ST_EMIT_RD;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.resp_code = code_reg;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.take_in  = in_valid;
            end
            ST_CHECK: begin
                cmd.cnt_clr = 1'b1;
            end
            ST_ROAD_WAIT: begin
                cmd.road_wr_ab = sts.is_add || sts.road_present;
            end
            ST_ROAD_WR2: cmd.road_wr_ba = 1'b1;
            ST_RESP: cmd.resp_load = sts.out_free;
            ST_INIT: begin
                cmd.init_step = 1'b1;
                cmd.cnt_clr   = sts.cnt_done;
                cmd.best_clr  = sts.cnt_done;
            end
            ST_SCAN: begin
                cmd.scan_step  = 1'b1;
                cmd.walk_start = sts.cnt_done && !sts.pipe_busy && !sts.found;
            end
            ST_SETTLE: begin
                cmd.settle_wr = 1'b1;
                cmd.cnt_clr   = 1'b1;
            end
            ST_RELAX: begin
                cmd.relax_step = 1'b1;
                cmd.cnt_clr    = sts.cnt_done && !sts.pipe_busy;
                cmd.best_clr   = sts.cnt_done && !sts.pipe_busy;
            end
            ST_WALK_RD: cmd.walk_rd = 1'b1;
            ST_WALK_EV: cmd.walk_push = !(sts.len_zero && !sts.rd_reached);
            ST_EMIT_RD: cmd.emit_load = 1'b0;
            ST_EMIT_OUT: cmd.emit_load = sts.out_free;
            default: cmd.in_ready = 1'b0;
        endcase
    end
endmodule

// File: rtl/brsp_datapath.sv
// Datapath: road table, per-node search table, route stack and output register.
// Depends on brsp_pkg and brsp_ram; steered by brsp_ctrl.
module brsp_datapath import brsp_pkg::*; #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [4:0]  cfg_data,
    input  logic [31:0] s_tdata,
    input  logic        m_tready,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        m_tvalid,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);
    localparam int NB = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = WEIGHT_BITS + NB;
    localparam int RW = WEIGHT_BITS + 2;
    localparam int NW = DW + NB + 2;
    localparam int RA = 2 * NB;
    localparam int RB = $clog2(ROUTE_MAX);

    logic [4:0]             node_count_reg;
    op_t                    op_reg;
    logic [3:0]             a_reg, b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [RA:0]            clr_cnt_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   pv_reg;
    logic [NB-1:0]          pidx_reg;
    logic                   found_reg;
    logic [NB-1:0]          best_idx_reg;
    logic [NW-1:0]          best_ent_reg;
    logic [RW-1:0]          road_new_reg;
    logic [NB-1:0]          cur_reg;
    logic [RB:0]            len_reg;
    logic [RB-1:0]          pos_reg;
    logic                   out_valid_reg;
    logic [3:0]             out_node_reg;
    logic                   out_last_reg;
    status_t                out_status_reg;

    logic [CW-1:0] n_eff;
    logic [NB-1:0] a_n, b_n, cnt_idx;
    logic          cnt_done, out_free;

    logic          road_we;
    logic [RA-1:0] road_waddr, road_raddr;
    logic [RW-1:0] road_wdata, road_rdata, road_new;
    logic [WEIGHT_BITS-1:0] road_w;
    logic          road_pres, road_blk;

    logic          node_we;
    logic [NB-1:0] node_waddr, node_raddr;
    logic [NW-1:0] node_wdata, node_rdata;
    logic [DW-1:0] e_dist, best_dist, cand;
    logic [NB-1:0] e_parent;
    logic          e_settled, e_reached;
    logic          scan_take, relax_take;

    logic [3:0]    stack_rdata;

    assign n_eff = (int'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_reg);
    assign a_n      = NB'(a_reg);
    assign b_n      = NB'(b_reg);
    assign cnt_idx  = cnt_reg[NB-1:0];
    assign cnt_done = (cnt_reg == n_eff);
    assign out_free = !out_valid_reg || m_tready;

    assign road_w    = road_rdata[WEIGHT_BITS-1:0];
    assign road_pres = road_rdata[WEIGHT_BITS];
    assign road_blk  = road_rdata[WEIGHT_BITS+1];

    assign e_dist    = node_rdata[DW-1:0];
    assign e_parent  = node_rdata[DW+NB-1:DW];
    assign e_settled = node_rdata[DW+NB];
    assign e_reached = node_rdata[DW+NB+1];
    assign best_dist = best_ent_reg[DW-1:0];
    assign cand      = best_dist + DW'(road_w);

    always_comb begin
        road_new = road_rdata;
        road_new[WEIGHT_BITS] = 1'b1;
        if (op_reg == OP_ADD) begin
            if (!road_pres || w_reg < road_w) road_new[WEIGHT_BITS-1:0] = w_reg;
        end else begin
            road_new[WEIGHT_BITS+1] = (op_reg == OP_BLOCK);
        end
    end

    assign scan_take = cmd.scan_step && pv_reg && e_reached && !e_settled &&
                       (!found_reg || e_dist < best_dist);
    assign relax_take = cmd.relax_step && pv_reg && road_pres && !road_blk &&
                        (!e_reached || cand < e_dist);

    always_comb begin
        road_we    = 1'b0;
        road_waddr = {a_n, b_n};
        road_wdata = road_new;
        if (cmd.clr_step) begin
            road_we    = !clr_cnt_reg[RA];
            road_waddr = clr_cnt_reg[RA-1:0];
            road_wdata = '0;
        end else if (cmd.road_wr_ab) begin
            road_we = 1'b1;
        end else if (cmd.road_wr_ba) begin
            road_we    = 1'b1;
            road_waddr = {b_n, a_n};
            road_wdata = road_new_reg;
        end
    end
    assign road_raddr = cmd.relax_step ? {best_idx_reg, cnt_idx} : {a_n, b_n};

    always_comb begin
        node_we    = 1'b0;
        node_waddr = cnt_idx;
        node_wdata = '0;
        if (cmd.init_step) begin
            node_we    = !cnt_done;
            node_wdata = {(cnt_idx == a_n), 1'b0, NB'(0), DW'(0)};
        end else if (cmd.settle_wr) begin
            node_we    = 1'b1;
            node_waddr = best_idx_reg;
            node_wdata = best_ent_reg;
            node_wdata[DW+NB] = 1'b1;
        end else if (relax_take) begin
            node_we    = 1'b1;
            node_waddr = pidx_reg;
            node_wdata = {1'b1, e_settled, best_idx_reg, cand};
        end
    end
    assign node_raddr = cmd.walk_rd ? cur_reg : cnt_idx;

    brsp_ram #(.WIDTH(RW), .DEPTH(2 ** RA)) u_road_ram (
        .aclk(aclk), .wr_en(road_we), .wr_addr(road_waddr), .wr_data(road_wdata),
        .rd_addr(road_raddr), .rd_data(road_rdata)
    );

    brsp_ram #(.WIDTH(NW), .DEPTH(2 ** NB)) u_node_ram (
        .aclk(aclk), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
        .rd_addr(node_raddr), .rd_data(node_rdata)
    );

    brsp_ram #(.WIDTH(4), .DEPTH(ROUTE_MAX)) u_stack_ram (
        .aclk(aclk), .wr_en(cmd.walk_push), .wr_addr(len_reg[RB-1:0]),
        .wr_data(4'(cur_reg)), .rd_addr(pos_reg), .rd_data(stack_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 5'd16;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (cfg_valid) node_count_reg <= cfg_data;
            if (cmd.clr_step && !clr_cnt_reg[RA]) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.resp_load || cmd.emit_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.cnt_clr) begin
                pv_reg <= 1'b0;
            end else if (cmd.scan_step || cmd.relax_step) begin
                pv_reg <= !cnt_done;
            end
            if (cmd.best_clr) begin
                found_reg <= 1'b0;
            end else if (scan_take) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            op_reg <= op_t'(s_tdata[1:0]);
            a_reg  <= s_tdata[5:2];
            b_reg  <= s_tdata[9:6];
            w_reg  <= WEIGHT_BITS'(s_tdata[25:10]);
        end
        if (cmd.road_wr_ab) road_new_reg <= road_new;
        if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if ((cmd.init_step || cmd.scan_step || cmd.relax_step) && !cnt_done) begin
            cnt_reg  <= cnt_reg + 1'b1;
            pidx_reg <= cnt_idx;
        end
        if (scan_take) begin
            best_idx_reg <= pidx_reg;
            best_ent_reg <= node_rdata;
        end
        if (cmd.walk_start) begin
            cur_reg <= b_n;
            len_reg <= '0;
        end else if (cmd.walk_push) begin
            cur_reg <= e_parent;
            len_reg <= len_reg + 1'b1;
            pos_reg <= len_reg[RB-1:0];
        end else if (cmd.emit_load) begin
            pos_reg <= pos_reg - 1'b1;
        end
        if (cmd.resp_load) begin
            out_node_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.resp_code;
        end else if (cmd.emit_load) begin
            out_node_reg   <= stack_rdata;
            out_last_reg   <= (pos_reg == '0);
            out_status_reg <= STS_OK;
        end
    end

    always_comb begin
        sts              = '0;
        sts.clr_done     = clr_cnt_reg[RA];
        sts.bad_index    = (int'(a_reg) >= int'(n_eff)) || (int'(b_reg) >= int'(n_eff));
        sts.is_query     = (op_reg == OP_QUERY);
        sts.is_add       = (op_reg == OP_ADD);
        sts.road_present = road_pres;
        sts.cnt_done     = cnt_done;
        sts.pipe_busy    = pv_reg;
        sts.found        = found_reg;
        sts.rd_reached   = e_reached;
        sts.len_zero     = (len_reg == '0);
        sts.walk_end     = (cur_reg == a_n) || (int'(len_reg) == ROUTE_MAX - 1);
        sts.pos_zero     = (pos_reg == '0);
        sts.out_free     = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_node_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;
endmodule

// File: rtl/blockable_road_shortest_path_top.sv
// Road ops: index check, then road-table writes a->b and b->a (skipped for a bad index or,
// on block and unblock, a missing road). Route query with n live nodes: clear the node
// table, then per settled node a node-table scan for the minimum, a settle and one
// road-table read per node; then a final scan, and a walk and an emit per route node.
// One item in flight; the next is taken once the last result sits in the output register.
// After reset the road table (2**(2*clog2(MAX_NODES)) entries, 256 by default) is cleared
// with s_tready low. node_count resets to 16; the user writes it between items (not enforced).
module blockable_road_shortest_path_top import brsp_pkg::*; #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // node_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // operation[1:0], first_node[5:2],
                                    // second_node[9:6], edge_weight[25:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // path_node[3:0]
    output logic        m_tlast,
    output logic [1:0]  m_tuser     // status[1:0]
);
`include "blockable_road_shortest_path_top_defines.svh"

    cmd_t cmd;
    sts_t sts;

    brsp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .sts(sts), .cmd(cmd)
    );

    brsp_datapath #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_datapath (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .s_tdata(s_tdata), .m_tready(m_tready), .cmd(cmd), .sts(sts),
        .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    `BRSP_ASSERT_IMP(a_status_single, aclk, aresetn, m_tvalid && m_tuser != STS_OK, m_tlast && m_tdata == 8'd0)
    `BRSP_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

// File: sim/tb_top.sv
// Testbench for the blockable road shortest path block: directed table, node-count corner cases, then random traffic.
// Route results are predicted by an in-bench shortest-path model; depends on brsp_pkg.
module tb_top import brsp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] node;
        logic       lst;
        status_t    sts;
    } route_item_t;

    typedef struct {
        op_t         op;
        logic [3:0]  a;
        logic [3:0]  b;
        logic [15:0] w;
        logic        typed;
        status_t     sts;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    blockable_road_shortest_path_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] road_w [256];
    logic        road_on [256];
    logic        road_blk [256];
    logic [4:0]  live_nodes;
    route_item_t expected_route[$];
    int          errors = 0;
    int          stall_hold = 0;

    task automatic queue_item(route_item_t r);
        expected_route = {expected_route, r};
    endtask

    task automatic push_status(status_t s);
        route_item_t r;
        r.node = 4'd0; r.lst = 1'b1; r.sts = s;
        queue_item(r);
    endtask

    task automatic predict_route(logic [3:0] src, logic [3:0] dst, int n);
        logic [19:0] node_dist [16];
        logic        seen [16];
        logic        done [16];
        logic [3:0]  par [16];
        logic [3:0]  stack [16];
        logic [19:0] cand;
        int u, len, k, e;
        logic       hit;
        logic [3:0] v;
        route_item_t r;
        for (int i = 0; i < 16; i++) begin
            node_dist[i] = 0; seen[i] = 0; done[i] = 0; par[i] = 0;
        end
        seen[src] = 1;
        for (k = 0; k < n; k++) begin
            hit = 0; u = 0;
            for (int i = 0; i < n; i++)
                if (seen[i] && !done[i] && (!hit || node_dist[i] < node_dist[u])) begin
                    u = i; hit = 1;
                end
            if (!hit) break;
            done[u] = 1;
            for (int j = 0; j < n; j++) begin
                e = u * 16 + j;
                if (road_on[e] && !road_blk[e]) begin
                    cand = node_dist[u] + road_w[e];
                    if (!seen[j] || cand < node_dist[j]) begin
                        node_dist[j] = cand; seen[j] = 1; par[j] = u[3:0];
                    end
                end
            end
        end
        if (!seen[dst]) begin
            push_status(STS_NO_ROUTE);
            return;
        end
        len = 0; v = dst;
        forever begin
            stack[len] = v; len++;
            if (v == src || len >= ROUTE_MAX) break;
            v = par[v];
        end
        for (k = 0; k < len; k++) begin
            r.node = stack[len - 1 - k]; r.lst = (k + 1 == len); r.sts = STS_OK;
            queue_item(r);
        end
    endtask

    task automatic predict_item(op_t op, logic [3:0] a, logic [3:0] b, logic [15:0] w);
        int n, ab, ba;
        n = (live_nodes > 16) ? 16 : live_nodes;
        ab = a * 16 + b; ba = b * 16 + a;
        if (a >= n || b >= n) push_status(STS_BAD_INDEX);
        else if (op == OP_QUERY) predict_route(a, b, n);
        else if (op == OP_ADD) begin
            if (!road_on[ab] || w < road_w[ab]) begin
                road_w[ab] = w; road_w[ba] = w;
            end
            road_on[ab] = 1; road_on[ba] = 1;
            push_status(STS_OK);
        end else if (!road_on[ab]) push_status(STS_NO_ROAD);
        else begin
            road_blk[ab] = (op == OP_BLOCK); road_blk[ba] = (op == OP_BLOCK);
            push_status(STS_OK);
        end
    endtask

    // sender: bursts and gaps, driven at the falling edge
    task automatic drive_item(op_t op, logic [3:0] a, logic [3:0] b, logic [15:0] w);
        if (!s_tvalid) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, w, b, a, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    task automatic send_item(op_t op, logic [3:0] a, logic [3:0] b, logic [15:0] w);
        predict_item(op, a, b, w);
        drive_item(op, a, b, w);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        while (expected_route.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    task automatic write_count(logic [4:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        live_nodes = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: own stall pattern plus one long hold-off
    always @(negedge aclk) begin
        if (stall_hold > 0) begin
            m_tready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end else
            m_tready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge aclk) begin
        route_item_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.node = m_tdata[3:0]; got.lst = m_tlast; got.sts = status_t'(m_tuser);
            if (expected_route.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: node %0d last %0b sts %0d",
                                           got.node, got.lst, got.sts);
            end else begin
                want = expected_route.pop_front();
                if (got !== want || m_tdata[7:4] !== 4'd0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp node %0d last %0b sts %0d, got %0d %0b %0d",
                                 want.node, want.lst, want.sts, got.node, got.lst, got.sts);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    stim_row_t table_rows[$];

    task automatic row(op_t op, int a, int b, int w, logic typed, status_t s);
        stim_row_t r;
        r.op = op; r.a = 4'(a); r.b = 4'(b); r.w = 16'(w); r.typed = typed; r.sts = s;
        table_rows = {table_rows, r};
    endtask

    task automatic random_phase(int items, int maxn);
        int a, b, k;
        op_t op;
        logic [15:0] w;
        for (k = 0; k < items; k++) begin
            a = $urandom_range(0, maxn - 1); b = $urandom_range(0, maxn - 1);
            if ($urandom_range(0, 15) == 0) begin
                a = $urandom_range(0, 15); b = $urandom_range(0, 15);
            end
            case ($urandom_range(0, 9)) inside
                [0:3]:   op = OP_ADD;
                4:       op = OP_BLOCK;
                5:       op = OP_UNBLOCK;
                default: op = OP_QUERY;
            endcase
            w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 40));
            send_item(op, 4'(a), 4'(b), w);
        end
    endtask

    initial begin
        route_item_t r;
        for (int i = 0; i < 256; i++) begin
            road_on[i] = 0; road_blk[i] = 0; road_w[i] = 0;
        end
        live_nodes = 5'd16;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        row(OP_BLOCK,   0, 1, 0,     1, STS_NO_ROAD);
        row(OP_QUERY,   0, 1, 0,     1, STS_NO_ROUTE);
        row(OP_QUERY,   15, 15, 0,   0, STS_OK);
        row(OP_ADD,     0, 1, 65535, 1, STS_OK);
        row(OP_ADD,     1, 2, 0,     1, STS_OK);
        row(OP_ADD,     0, 1, 3,     1, STS_OK);
        row(OP_ADD,     0, 1, 9,     1, STS_OK);
        row(OP_ADD,     0, 2, 2,     1, STS_OK);
        row(OP_ADD,     2, 2, 0,     1, STS_OK);
        row(OP_BLOCK,   2, 2, 0,     1, STS_OK);
        row(OP_QUERY,   0, 2, 0,     0, STS_OK);
        row(OP_QUERY,   2, 0, 0,     0, STS_OK);
        row(OP_BLOCK,   0, 2, 0,     1, STS_OK);
        row(OP_QUERY,   0, 2, 0,     0, STS_OK);
        row(OP_UNBLOCK, 2, 0, 0,     1, STS_OK);
        row(OP_UNBLOCK, 5, 6, 0,     1, STS_NO_ROAD);
        row(OP_ADD,     15, 14, 100, 1, STS_OK);
        row(OP_QUERY,   0, 15, 0,    1, STS_NO_ROUTE);
        row(OP_ADD,     2, 14, 1,    1, STS_OK);
        row(OP_QUERY,   15, 0, 0,    0, STS_OK);
        row(OP_QUERY,   1, 1, 0,     0, STS_OK);
        for (int i = 0; i < table_rows.size(); i++) begin
            predict_item(table_rows[i].op, table_rows[i].a, table_rows[i].b,
                         table_rows[i].w);
            if (table_rows[i].typed) begin
                r = expected_route.pop_back();
                if (r.sts !== table_rows[i].sts || !r.lst) begin
                    errors++;
                    if (errors <= 10)
                        $display("table row %0d: predictor disagrees with typed status", i);
                end
                r.sts = table_rows[i].sts; r.lst = 1'b1; r.node = 4'd0;
                queue_item(r);
            end
            drive_item(table_rows[i].op, table_rows[i].a, table_rows[i].b,
                       table_rows[i].w);
        end
        drain_and_idle();

        write_count(5'd0);
        send_item(OP_QUERY, 4'd0, 4'd0, 16'd0);
        send_item(OP_ADD, 4'd0, 4'd0, 16'd1);
        drain_and_idle();
        write_count(5'd1);
        send_item(OP_QUERY, 4'd0, 4'd0, 16'd0);
        send_item(OP_ADD, 4'd0, 4'd1, 16'd1);
        drain_and_idle();
        write_count(5'd31);
        stall_hold = 2000;
        random_phase(82, 16);
        drain_and_idle();
        write_count(5'd4);
        random_phase(82, 5);
        drain_and_idle();
        write_count(5'd16);
        random_phase(82, 16);
        drain_and_idle();

        if (errors == 0 && expected_route.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/brsp_pkg.sv
rtl/brsp_ram.sv
rtl/brsp_ctrl.sv
rtl/brsp_datapath.sv
rtl/blockable_road_shortest_path_top.sv
sim/tb_top.sv
